// File: rtl/core/bce_pkg.sv
// Shared types and constants for the bitmask collision engine.
// Used by bce_row_unit and the top level; depends on nothing.

package bce_pkg;

  localparam int DIM_W   = 7;
  localparam int ALPHA_W = 8;
  localparam int MODE_W  = 3;
  localparam int CFG_IDX_W = 3;

  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 8'd128;

  typedef enum logic [MODE_W-1:0] {
    MODE_WRITE_A = 3'd0,
    MODE_WRITE_B = 3'd1,
    MODE_FILL_A  = 3'd2,
    MODE_FILL_B  = 3'd3,
    MODE_POINT   = 3'd4,
    MODE_BOX     = 3'd5,
    MODE_OVERLAP = 3'd6,
    MODE_NOP     = 3'd7
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_A_WIDTH   = 3'd0,
    CFG_A_HEIGHT  = 3'd1,
    CFG_B_WIDTH   = 3'd2,
    CFG_B_HEIGHT  = 3'd3,
    CFG_THRESHOLD = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_WRITE,
    ST_POINT,
    ST_SCAN,
    ST_DONE
  } state_e;

  // Row evaluation control, set once per query.
  typedef struct packed {
    logic overlap;
    logic shift_right;
  } row_ctrl_t;

endpackage

// File: rtl/core/bce_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.

module bce_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/bce_row_unit.sv
// Shared row evaluator: aligns a B row to A by a barrel shift, masks columns
// and reduces to a single hit flag. Depends on bce_pkg.

module bce_row_unit #(
  parameter int MASK_SIZE = 64
) (
  input  logic [MASK_SIZE-1:0]         a_row,
  input  logic [MASK_SIZE-1:0]         b_row,
  input  logic [MASK_SIZE-1:0]         col_mask,
  input  logic [$clog2(MASK_SIZE)-1:0] shamt,
  input  bce_pkg::row_ctrl_t           ctrl,
  output logic                         row_hit
);

  logic [MASK_SIZE-1:0] b_aligned;
  logic [MASK_SIZE-1:0] cand;

  // Column x of A meets column x - offset of B.
  assign b_aligned = ctrl.shift_right ? (b_row >> shamt) : (b_row << shamt);
  assign cand      = ctrl.overlap ? b_aligned : {MASK_SIZE{1'b1}};
  assign row_hit   = |(a_row & col_mask & cand);

endmodule

// File: rtl/core/bitmask_collision_engine_top.sv
// Top level of the bitmask collision engine: config registers, sequencer,
// two mask RAMs with per-row valid bits. Depends on bce_pkg, bce_ram, bce_row_unit.
//
//  channel  signals                               direction  width
//  cfg      cfg_valid/cfg_ready, cfg_index, cfg_data  in     3 + 8
//  in       in_valid/in_ready, mode..box_height   in         3+2*CB+8+1+2*CB
//  out      out_valid/out_ready, hit, out_of_range out       1 + 1
//
// A fill, a nop, an out-of-range write or point, or an empty box or overlap
// region is answered from setup; a write or point passes through its own
// state first, and a box or overlap scans the rows of its region. The scan
// reads one row of each mask RAM per cycle through a single read port, and
// stops early on the first hit. in_ready is high only while the sequencer is idle.
// Reset clears the row valid bits, so both masks read clear at once; an
// unwritten or filled row reads as the mask's fill value. A stalled result
// holds the sequencer in its final state.

module bitmask_collision_engine_top #(
  parameter int MASK_SIZE  = 64,
  parameter int COORD_BITS = 12
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bce_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bce_pkg::ALPHA_W-1:0]     cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [bce_pkg::MODE_W-1:0]      mode,
  input  logic signed [COORD_BITS-1:0]    pos_x,
  input  logic signed [COORD_BITS-1:0]    pos_y,
  input  logic [bce_pkg::ALPHA_W-1:0]     alpha,
  input  logic                            fill_value,
  input  logic [COORD_BITS-1:0]           box_width,
  input  logic [COORD_BITS-1:0]           box_height,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            hit,
  output logic                            out_of_range
);

  localparam int CB = COORD_BITS;
  localparam int EW = COORD_BITS + 2;
  localparam int CW = $clog2(MASK_SIZE + 1);
  localparam int RW = $clog2(MASK_SIZE);
  localparam int WW = (CW > bce_pkg::DIM_W) ? CW : bce_pkg::DIM_W;
  localparam logic signed [EW-1:0] MASK_E = EW'(MASK_SIZE);

  // Configuration registers
  logic [bce_pkg::DIM_W-1:0]   mask_a_width, mask_a_height;
  logic [bce_pkg::DIM_W-1:0]   mask_b_width, mask_b_height;
  logic [bce_pkg::ALPHA_W-1:0] alpha_threshold;

  // Latched request
  bce_pkg::mode_e          mode_q;
  logic signed [CB-1:0]    px_q, py_q;
  logic [bce_pkg::ALPHA_W-1:0] alpha_q;
  logic                    fill_in_q;
  logic [CB-1:0]           bw_q, bh_q;

  // Sequencer and scan state
  bce_pkg::state_e         state, state_next;
  logic [CW-1:0]           y_q, ey_q;
  logic                    pend_q;
  logic [MASK_SIZE-1:0]    col_mask_q;
  logic [RW-1:0]           shamt_q;
  bce_pkg::row_ctrl_t      ctrl_q;
  logic                    res_hit, res_oor;

  // Mask storage
  logic [MASK_SIZE-1:0]    valid_a, valid_b;
  logic                    fill_a, fill_b;
  logic                    rvalid_a_q, rvalid_b_q;
  logic [MASK_SIZE-1:0]    rdata_a, rdata_b, row_a, row_b, wr_row;
  logic [RW-1:0]           rd_addr_a, rd_addr_b, px_idx, py_idx, y_idx;

  // Clamped sizes
  logic [WW-1:0] wa_raw, ha_raw, wb_raw, hb_raw;
  logic [CW-1:0] wa, ha, wb, hb;

  // Setup arithmetic
  logic signed [EW-1:0] px_e, py_e, ext_x, ext_y, end_x, end_y;
  logic signed [EW-1:0] wa_e, ha_e, wsel_e, hsel_e, px_mag;
  logic [CW-1:0]        sx_c, sy_c, ex_c, ey_c;
  logic [MASK_SIZE-1:0] col_mask_c;
  logic                 empty_c, oor_c;

  // Sequencer strobes
  logic in_accept, cfg_accept, scan_issue, row_hit, solid;
  logic we_a, we_b, fill_a_en, fill_b_en, res_set, res_hit_set, res_oor_set;
  logic out_load;

  assign cfg_ready  = 1'b1;
  assign cfg_accept = cfg_valid & cfg_ready;
  assign in_ready   = (state == bce_pkg::ST_IDLE);
  assign in_accept  = in_valid & in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mask_a_width    <= '0;
      mask_a_height   <= '0;
      mask_b_width    <= '0;
      mask_b_height   <= '0;
      alpha_threshold <= bce_pkg::ALPHA_RESET;
    end else if (cfg_accept) begin
      case (bce_pkg::cfg_idx_e'(cfg_index))
        bce_pkg::CFG_A_WIDTH:   mask_a_width    <= cfg_data[bce_pkg::DIM_W-1:0];
        bce_pkg::CFG_A_HEIGHT:  mask_a_height   <= cfg_data[bce_pkg::DIM_W-1:0];
        bce_pkg::CFG_B_WIDTH:   mask_b_width    <= cfg_data[bce_pkg::DIM_W-1:0];
        bce_pkg::CFG_B_HEIGHT:  mask_b_height   <= cfg_data[bce_pkg::DIM_W-1:0];
        bce_pkg::CFG_THRESHOLD: alpha_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sizes above the storage read as the storage size
  assign wa_raw = WW'(mask_a_width);
  assign ha_raw = WW'(mask_a_height);
  assign wb_raw = WW'(mask_b_width);
  assign hb_raw = WW'(mask_b_height);
  assign wa = (wa_raw > WW'(MASK_SIZE)) ? CW'(MASK_SIZE) : CW'(wa_raw);
  assign ha = (ha_raw > WW'(MASK_SIZE)) ? CW'(MASK_SIZE) : CW'(ha_raw);
  assign wb = (wb_raw > WW'(MASK_SIZE)) ? CW'(MASK_SIZE) : CW'(wb_raw);
  assign hb = (hb_raw > WW'(MASK_SIZE)) ? CW'(MASK_SIZE) : CW'(hb_raw);

  always_ff @(posedge clk) begin
    if (in_accept) begin
      mode_q    <= bce_pkg::mode_e'(mode);
      px_q      <= pos_x;
      py_q      <= pos_y;
      alpha_q   <= alpha;
      fill_in_q <= fill_value;
      bw_q      <= box_width;
      bh_q      <= box_height;
    end
  end

  // Region bounds: [sx, ex) x [sy, ey), clipped to mask A
  assign px_e = {{2{px_q[CB-1]}}, px_q};
  assign py_e = {{2{py_q[CB-1]}}, py_q};
  assign wa_e = signed'({{(EW-CW){1'b0}}, wa});
  assign ha_e = signed'({{(EW-CW){1'b0}}, ha});
  assign ext_x = (mode_q == bce_pkg::MODE_BOX) ? signed'({2'b00, bw_q})
                                               : signed'({{(EW-CW){1'b0}}, wb});
  assign ext_y = (mode_q == bce_pkg::MODE_BOX) ? signed'({2'b00, bh_q})
                                               : signed'({{(EW-CW){1'b0}}, hb});
  assign end_x = px_e + ext_x;
  assign end_y = py_e + ext_y;

  always_comb begin
    if (px_e < 0)           sx_c = '0;
    else if (px_e > MASK_E) sx_c = CW'(MASK_SIZE);
    else                    sx_c = px_e[CW-1:0];
    if (py_e < 0)           sy_c = '0;
    else if (py_e > MASK_E) sy_c = CW'(MASK_SIZE);
    else                    sy_c = py_e[CW-1:0];
    if (end_x < 0)          ex_c = '0;
    else if (end_x > wa_e)  ex_c = wa;
    else                    ex_c = end_x[CW-1:0];
    if (end_y < 0)          ey_c = '0;
    else if (end_y > ha_e)  ey_c = ha;
    else                    ey_c = end_y[CW-1:0];
    for (int i = 0; i < MASK_SIZE; i++) begin
      col_mask_c[i] = (CW'(i) >= sx_c) && (CW'(i) < ex_c);
    end
  end

  assign empty_c = (sx_c >= ex_c) || (sy_c >= ey_c);
  assign px_mag  = px_e[EW-1] ? -px_e : px_e;

  assign wsel_e = (mode_q == bce_pkg::MODE_WRITE_B) ? signed'({{(EW-CW){1'b0}}, wb}) : wa_e;
  assign hsel_e = (mode_q == bce_pkg::MODE_WRITE_B) ? signed'({{(EW-CW){1'b0}}, hb}) : ha_e;
  assign oor_c  = (px_e < 0) || (px_e >= wsel_e) || (py_e < 0) || (py_e >= hsel_e);

  // Memory addressing
  assign px_idx = px_q[RW-1:0];
  assign py_idx = py_q[RW-1:0];
  assign y_idx  = y_q[RW-1:0];
  assign scan_issue = (y_q < ey_q);

  always_comb begin
    if (state == bce_pkg::ST_SCAN) begin
      rd_addr_a = y_idx;
      rd_addr_b = y_idx - py_idx;
    end else begin
      rd_addr_a = py_idx;
      rd_addr_b = py_idx;
    end
  end

  assign row_a = rvalid_a_q ? rdata_a : {MASK_SIZE{fill_a}};
  assign row_b = rvalid_b_q ? rdata_b : {MASK_SIZE{fill_b}};
  assign solid = (alpha_q >= alpha_threshold);

  always_comb begin
    wr_row = (mode_q == bce_pkg::MODE_WRITE_B) ? row_b : row_a;
    wr_row[px_idx] = solid;
  end

  bce_ram #(.WIDTH(MASK_SIZE), .DEPTH(MASK_SIZE)) u_ram_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (py_idx),
    .wdata (wr_row),
    .raddr (rd_addr_a),
    .rdata (rdata_a)
  );

  bce_ram #(.WIDTH(MASK_SIZE), .DEPTH(MASK_SIZE)) u_ram_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (py_idx),
    .wdata (wr_row),
    .raddr (rd_addr_b),
    .rdata (rdata_b)
  );

  bce_row_unit #(.MASK_SIZE(MASK_SIZE)) u_row_unit (
    .a_row    (row_a),
    .b_row    (row_b),
    .col_mask (col_mask_q),
    .shamt    (shamt_q),
    .ctrl     (ctrl_q),
    .row_hit  (row_hit)
  );

  // Row valid bits and fill values
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a <= '0;
      valid_b <= '0;
      fill_a  <= 1'b0;
      fill_b  <= 1'b0;
    end else begin
      if (fill_a_en) begin
        valid_a <= '0;
        fill_a  <= fill_in_q;
      end else if (we_a) begin
        valid_a[py_idx] <= 1'b1;
      end
      if (fill_b_en) begin
        valid_b <= '0;
        fill_b  <= fill_in_q;
      end else if (we_b) begin
        valid_b[py_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rvalid_a_q <= valid_a[rd_addr_a];
    rvalid_b_q <= valid_b[rd_addr_b];
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= bce_pkg::ST_IDLE;
      pend_q <= 1'b0;
    end else begin
      state  <= state_next;
      pend_q <= (state == bce_pkg::ST_SCAN) && scan_issue;
    end
  end

  always_comb begin
    state_next  = state;
    we_a        = 1'b0;
    we_b        = 1'b0;
    fill_a_en   = 1'b0;
    fill_b_en   = 1'b0;
    res_set     = 1'b0;
    res_hit_set = 1'b0;
    res_oor_set = 1'b0;
    out_load    = 1'b0;
    case (state)
      bce_pkg::ST_IDLE: begin
        if (in_valid) state_next = bce_pkg::ST_SETUP;
      end
      bce_pkg::ST_SETUP: begin
        case (mode_q)
          bce_pkg::MODE_WRITE_A, bce_pkg::MODE_WRITE_B: begin
            if (oor_c) begin
              res_set     = 1'b1;
              res_oor_set = 1'b1;
              state_next  = bce_pkg::ST_DONE;
            end else begin
              state_next  = bce_pkg::ST_WRITE;
            end
          end
          bce_pkg::MODE_FILL_A: begin
            fill_a_en  = 1'b1;
            res_set    = 1'b1;
            state_next = bce_pkg::ST_DONE;
          end
          bce_pkg::MODE_FILL_B: begin
            fill_b_en  = 1'b1;
            res_set    = 1'b1;
            state_next = bce_pkg::ST_DONE;
          end
          bce_pkg::MODE_POINT: begin
            if (oor_c) begin
              res_set     = 1'b1;
              res_oor_set = 1'b1;
              state_next  = bce_pkg::ST_DONE;
            end else begin
              state_next  = bce_pkg::ST_POINT;
            end
          end
          bce_pkg::MODE_BOX, bce_pkg::MODE_OVERLAP: begin
            if (empty_c) begin
              res_set    = 1'b1;
              state_next = bce_pkg::ST_DONE;
            end else begin
              state_next = bce_pkg::ST_SCAN;
            end
          end
          default: begin
            res_set    = 1'b1;
            state_next = bce_pkg::ST_DONE;
          end
        endcase
      end
      bce_pkg::ST_WRITE: begin
        we_a       = (mode_q == bce_pkg::MODE_WRITE_A);
        we_b       = (mode_q == bce_pkg::MODE_WRITE_B);
        res_set    = 1'b1;
        state_next = bce_pkg::ST_DONE;
      end
      bce_pkg::ST_POINT: begin
        res_set     = 1'b1;
        res_hit_set = row_a[px_idx];
        state_next  = bce_pkg::ST_DONE;
      end
      bce_pkg::ST_SCAN: begin
        // Evaluate the row read last cycle while the next one is fetched
        if (pend_q && row_hit) begin
          res_set     = 1'b1;
          res_hit_set = 1'b1;
          state_next  = bce_pkg::ST_DONE;
        end else if (!scan_issue && !pend_q) begin
          res_set    = 1'b1;
          state_next = bce_pkg::ST_DONE;
        end
      end
      bce_pkg::ST_DONE: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = bce_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = bce_pkg::ST_IDLE;
      end
    endcase
  end

  // Scan datapath
  always_ff @(posedge clk) begin
    if (state == bce_pkg::ST_SETUP) begin
      y_q                <= sy_c;
      ey_q               <= ey_c;
      col_mask_q         <= col_mask_c;
      shamt_q            <= px_mag[RW-1:0];
      ctrl_q.overlap     <= (mode_q == bce_pkg::MODE_OVERLAP);
      ctrl_q.shift_right <= px_e[EW-1];
    end else if (state == bce_pkg::ST_SCAN && scan_issue) begin
      y_q <= y_q + 1'b1;
    end
    if (res_set) begin
      res_hit <= res_hit_set;
      res_oor <= res_oor_set;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      hit          <= res_hit;
      out_of_range <= res_oor;
    end
  end

endmodule
